// ===== design/sdf_pkg.sv =====
`default_nettype none
package sdf_pkg;

  // Default cap on the number of characters in one field
  localparam int MAX_FIELD_DEF = 64;

  // Decimal conversion: 64 magnitude bits, 20 BCD digits, 4 bits per cycle
  localparam int MAG_W   = 64;
  localparam int NDIG    = 20;
  localparam int BCD_W   = NDIG * 4;
  localparam int BPS     = 4;
  localparam int NSTEP   = MAG_W / BPS;
  localparam int STEP_W  = $clog2(NSTEP);
  localparam int NDIG_W  = $clog2(NDIG + 1);
  localparam int DIGI_W  = $clog2(NDIG);
  // Field lengths reach 64 (sign plus 63 digits), so 7 bits
  localparam int LEN_W   = 7;

  // Size modes
  localparam logic [2:0] MODE_INT   = 3'd0;
  localparam logic [2:0] MODE_SHORT = 3'd1;
  localparam logic [2:0] MODE_CHAR  = 3'd2;
  localparam logic [2:0] MODE_LONG  = 3'd3;
  localparam logic [2:0] MODE_LLONG = 3'd4;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         size_mode;
    logic [5:0]         min_width;
    logic [5:0]         precision;
    logic               precision_given;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // One classified field, handed from front to back
  typedef struct packed {
    logic [BCD_W-1:0]  bcd;    // decimal digits, digit 0 in the low nibble
    logic [NDIG_W-1:0] nd;     // significant digits
    logic [5:0]        dlen;   // digits after zero padding
    logic              neg;
    logic [LEN_W-1:0]  total;  // full field length
    logic [LEN_W-1:0]  emit;   // characters sent, after the cap
  } desc_t;

endpackage
`default_nettype wire

// ===== design/signed_decimal_field_formatter.sv =====
`default_nettype none
// Formats one signed integer per input item as printf %d does without flags:
// the value is cut to its size mode (int, short, signed char, long, long
// long) and sign-extended, its magnitude is written in decimal, zero-padded
// to the precision, given a '-' when negative and space-padded on the left to
// min_width. The characters leave one item per cycle while out_ready holds,
// left to right, with last set on the final one; fields longer than MAX_FIELD
// are cut to their first MAX_FIELD characters, and a zero with precision 0
// and width 0 gives nothing. The front accepts an item, runs the binary-to-BCD
// conversion at four bits per cycle, then classifies and queues it, and takes
// no new item until that field is queued or dropped. The back sends one
// character per cycle while out_ready holds; a two-entry queue between them
// lets a new conversion run while an earlier field is still going out.
module signed_decimal_field_formatter #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sdf_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sdf_pkg::out_item_t      out_data
);
  import sdf_pkg::*;

  desc_t fq_wdata;
  desc_t fq_rdata;
  logic  fq_wvalid;
  logic  fq_wready;
  logic  fq_rvalid;
  logic  fq_pop;

  // Accept, truncate and convert to decimal
  sdf_front #(
    .MAX_FIELD (MAX_FIELD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_wvalid),
    .q_ready  (fq_wready),
    .q_data   (fq_wdata)
  );

  sdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_wvalid),
    .wr_ready (fq_wready),
    .wr_data  (fq_wdata),
    .rd_valid (fq_rvalid),
    .rd_pop   (fq_pop),
    .rd_data  (fq_rdata)
  );

  // Character emission
  sdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (fq_rvalid),
    .q_pop     (fq_pop),
    .q_data    (fq_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== design/sdf_front.sv =====
`default_nettype none
module sdf_front #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sdf_pkg::in_item_t in_data,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output sdf_pkg::desc_t        q_data
);
  import sdf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              neg_r, neg_nxt;
  logic [5:0]        width_r, width_nxt;
  logic [5:0]        prec_r, prec_nxt;

  logic [MAG_W-1:0]  sx;
  logic              sneg;
  logic [MAG_W-1:0]  dd_m;
  logic [BCD_W-1:0]  dd_b;
  logic [NDIG_W-1:0] nd;
  logic [5:0]        dlen;
  logic [LEN_W-1:0]  body;
  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  emit;

  assign in_ready = (state_r == S_IDLE);

  // Truncate to the size mode and sign-extend
  always_comb begin
    case (in_data.size_mode)
      MODE_SHORT: sx = MAG_W'({{48{in_data.value[15]}}, in_data.value[15:0]});
      MODE_CHAR:  sx = MAG_W'({{56{in_data.value[7]}}, in_data.value[7:0]});
      MODE_LONG,
      MODE_LLONG: sx = MAG_W'(in_data.value);
      default:    sx = MAG_W'({{32{in_data.value[31]}}, in_data.value[31:0]});
    endcase
    sneg = sx[MAG_W-1];
  end

  // Shift-add-3 binary to BCD, BPS magnitude bits per cycle
  always_comb begin
    dd_b = bcd_r;
    dd_m = mag_r;
    for (int s = 0; s < BPS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dd_b[d*4 +: 4] >= 4'd5) begin
          dd_b[d*4 +: 4] = dd_b[d*4 +: 4] + 4'd3;
        end
      end
      dd_b = {dd_b[BCD_W-2:0], dd_m[MAG_W-1]};
      dd_m = {dd_m[MAG_W-2:0], 1'b0};
    end
  end

  // Field layout from the finished digits
  always_comb begin
    nd = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) begin
        nd = NDIG_W'(d + 1);
      end
    end
    dlen  = (prec_r > 6'(nd)) ? prec_r : 6'(nd);
    body  = LEN_W'(dlen) + LEN_W'(neg_r);
    total = (body > LEN_W'(width_r)) ? body : LEN_W'(width_r);
    emit  = (total > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : total;
  end

  assign q_valid      = (state_r == S_FIN) && (emit != '0);
  assign q_data.bcd   = bcd_r;
  assign q_data.nd    = nd;
  assign q_data.dlen  = dlen;
  assign q_data.neg   = neg_r;
  assign q_data.total = total;
  assign q_data.emit  = emit;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    width_nxt = width_r;
    prec_nxt  = prec_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt   = sneg ? (~sx + MAG_W'(1)) : sx;
          bcd_nxt   = '0;
          step_nxt  = '0;
          neg_nxt   = sneg;
          width_nxt = in_data.min_width;
          prec_nxt  = in_data.precision_given ? in_data.precision : 6'd1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        mag_nxt  = dd_m;
        bcd_nxt  = dd_b;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NSTEP - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // empty fields are dropped here
        if (emit == '0 || q_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r   <= mag_nxt;
    bcd_r   <= bcd_nxt;
    step_r  <= step_nxt;
    neg_r   <= neg_nxt;
    width_r <= width_nxt;
    prec_r  <= prec_nxt;
  end

endmodule
`default_nettype wire

// ===== design/sdf_queue.sv =====
`default_nettype none
module sdf_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire sdf_pkg::desc_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_pop,
  output sdf_pkg::desc_t      rd_data
);
  import sdf_pkg::*;

  // Two-entry field queue between front and back
  desc_t      mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/sdf_back.sv =====
`default_nettype none
module sdf_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire sdf_pkg::desc_t    q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sdf_pkg::out_item_t     out_data
);
  import sdf_pkg::*;

  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         od_r, od_nxt;
  logic              load;
  logic              is_last;
  logic [LEN_W-1:0]  k;
  logic [DIGI_W-1:0] di;
  logic [7:0]        ch;

  // Position of the next character counted from the right end of the field
  assign k       = q_data.total - LEN_W'(1) - cnt_r;
  assign di      = k[DIGI_W-1:0];
  assign is_last = (cnt_r == q_data.emit - LEN_W'(1));
  assign load    = q_valid && (!ov_r || out_ready);
  assign q_pop   = load && is_last;

  // Digits, then zero padding, then sign, then spaces
  always_comb begin
    if (k < LEN_W'(q_data.nd)) begin
      ch = CH_ZERO + 8'(q_data.bcd[di*4 +: 4]);
    end else if (k < LEN_W'(q_data.dlen)) begin
      ch = CH_ZERO;
    end else if (q_data.neg && k == LEN_W'(q_data.dlen)) begin
      ch = CH_MINUS;
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    if (load) begin
      ov_nxt           = 1'b1;
      od_nxt.character = ch;
      od_nxt.last      = is_last;
      cnt_nxt          = is_last ? '0 : cnt_r + LEN_W'(1);
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
    od_r <= od_nxt;
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  import sdf_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 11;
  localparam int CYCLE_LIMIT = 300000;
  // wait out any conversion still in the front end; leave room for the queue
  localparam int SETTLE_GAP  = 60;

  // size modes with no meaning of their own; they behave as int
  localparam logic [2:0] MODE_RSV5 = 3'd5;
  localparam logic [2:0] MODE_RSV6 = 3'd6;
  localparam logic [2:0] MODE_RSV7 = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // characters still owed by the block, oldest first
  out_item_t field_chars[$];

  typedef struct {
    in_item_t stim;
    bit       has_text;
    string    text;
  } dir_row_t;

  dir_row_t dir_rows[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_fields = 0;
  int n_chars = 0;
  int n_errors = 0;
  int cycle_count = 0;

  signed_decimal_field_formatter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, field_chars.size());
      $display("[signed_decimal_field_formatter] ERROR");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted character with the oldest one owed
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_chars++;
      if (field_chars.size() == 0) begin
        $error("unexpected character: character=%h last=%b",
               out_data.character, out_data.last);
        n_errors++;
      end else begin
        want = field_chars.pop_front();
        if (out_data.character !== want.character) begin
          $error("character: expected %h, actual %h", want.character, out_data.character);
          n_errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_data.last);
          n_errors++;
        end
      end
    end
  end

  // Work out the characters of one %d conversion
  function automatic void predict_field(input in_item_t it);
    int unsigned nbits, ndig, prec, body, total, emit;
    logic [63:0] mask, x, mag;
    logic        neg;
    logic [7:0]  digs[$];
    logic [7:0]  text[$];
    out_item_t   ch;
    case (it.size_mode)
      MODE_SHORT: nbits = 16;
      MODE_CHAR: nbits = 8;
      MODE_LONG, MODE_LLONG: nbits = 64;
      default: nbits = 32;
    endcase
    mask = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
    x = it.value & mask;
    neg = x[nbits-1];
    mag = neg ? ((~x + 64'd1) & mask) : x;
    // most significant digit ends up at the front
    while (mag != 0) begin
      digs.push_front(CH_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end
    ndig = digs.size();
    prec = it.precision_given ? 32'(it.precision) : 32'd1;
    body = ((ndig > prec) ? ndig : prec) + (neg ? 1 : 0);
    total = (body > 32'(it.min_width)) ? body : 32'(it.min_width);
    repeat (total - body) text.push_back(CH_SPACE);
    if (neg) text.push_back(CH_MINUS);
    if (prec > ndig) repeat (prec - ndig) text.push_back(CH_ZERO);
    foreach (digs[i]) text.push_back(digs[i]);
    emit = (total > MAX_FIELD_DEF) ? MAX_FIELD_DEF : total;
    for (int unsigned i = 0; i < emit; i++) begin
      ch.character = text[i];
      ch.last = (i + 1 == emit);
      field_chars.push_back(ch);
    end
  endfunction

  // Characters typed in by hand
  function automatic void owe_text(input string s);
    out_item_t ch;
    for (int i = 0; i < s.len(); i++) begin
      ch.character = s[i];
      ch.last = (i == s.len() - 1);
      field_chars.push_back(ch);
    end
  endfunction

  function automatic void add_row(input logic [63:0] value, input logic [2:0] mode,
                                  input int width, input int prec, input bit given,
                                  input bit has_text, input string text);
    dir_row_t r;
    r.stim.value = value;
    r.stim.size_mode = mode;
    r.stim.min_width = 6'(width);
    r.stim.precision = 6'(prec);
    r.stim.precision_given = given;
    r.has_text = has_text;
    r.text = text;
    dir_rows.push_back(r);
  endfunction

  function automatic in_item_t rand_field();
    in_item_t    it;
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = 64'($urandom_range(20));
      1: v = -64'($urandom_range(20));
      2: v = 64'd0;
      3: v = {$urandom_range(1) ? 1'b1 : 1'b0, 63'd0} | ($urandom_range(1) ? 64'h7FFF : 64'h80);
      4: v = v >>> $urandom_range(63);
      default: ;
    endcase
    it.value = v;
    it.size_mode = 3'($urandom_range(7));
    it.precision_given = 1'($urandom_range(1));
    // mostly short fields, now and then a wide one
    it.min_width = 6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(12));
    it.precision = 6'(($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(6));
    return it;
  endfunction

  // Offer one item and book its characters once it is taken
  task automatic send_item(input in_item_t it, input bit has_text, input string text);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (has_text) owe_text(text);
    else predict_field(it);
    n_fields++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_item(rand_field(), 1'b0, "");
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (field_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  initial begin
    // value, mode, width, precision, given, typed?, text
    add_row(64'd0, MODE_INT, 0, 0, 0, 1, "0");
    add_row(64'd0, MODE_INT, 0, 0, 1, 1, "");
    add_row(64'd0, MODE_INT, 5, 0, 1, 1, "     ");
    add_row(64'd0, MODE_INT, 1, 0, 1, 1, " ");
    add_row(64'hFFFF_FFFF_8000_0000, MODE_INT, 0, 0, 0, 1, "-2147483648");
    add_row(64'h0000_0000_7FFF_FFFF, MODE_INT, 0, 0, 0, 1, "2147483647");
    add_row(64'h0000_0000_0000_8000, MODE_SHORT, 0, 0, 0, 1, "-32768");
    add_row(64'hFFFF_FFFF_0001_7FFF, MODE_SHORT, 0, 0, 0, 1, "32767");
    add_row(64'h0000_0000_0000_0080, MODE_CHAR, 0, 0, 0, 1, "-128");
    add_row(64'h0000_0000_0000_007F, MODE_CHAR, 0, 0, 0, 1, "127");
    add_row(64'h1234_5678_9ABC_DEFF, MODE_CHAR, 0, 0, 0, 1, "-1");
    add_row(64'h8000_0000_0000_0000, MODE_LONG, 0, 0, 0, 1, "-9223372036854775808");
    add_row(64'h7FFF_FFFF_FFFF_FFFF, MODE_LLONG, 0, 0, 0, 1, "9223372036854775807");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, MODE_LLONG, 0, 0, 0, 1, "-1");
    add_row(64'h0000_0001_0000_0005, MODE_RSV5, 0, 0, 0, 1, "5");
    add_row(64'hFFFF_FFFF_FFFF_FFFF, MODE_RSV6, 0, 0, 0, 1, "-1");
    add_row(64'h0000_0000_FFFF_FFFF, MODE_RSV7, 0, 0, 0, 1, "-1");
    add_row(-64'sd5, MODE_INT, 6, 3, 1, 1, "  -005");
    add_row(64'd123, MODE_INT, 0, 2, 1, 1, "123");
    add_row(64'd7, MODE_LONG, 0, 0, 1, 1, "7");
    // wide fields and alternating bit patterns go through the predictor
    add_row(64'd42, MODE_INT, 63, 0, 0, 0, "");
    add_row(64'h8000_0000_0000_0000, MODE_LONG, 63, 62, 1, 0, "");
    add_row(-64'sd9, MODE_LLONG, 0, 63, 1, 0, "");
    add_row(64'hAAAA_AAAA_AAAA_AAAA, MODE_LONG, 30, 25, 1, 0, "");
    add_row(64'h5555_5555_5555_5555, MODE_LLONG, 21, 15, 1, 0, "");

    // reset
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // slow sender, busy receiver
    send_idle_pct = 15;
    recv_idle_pct = 49;
    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].has_text, dir_rows[i].text);
    send_random(29);
    settle();

    // roles swapped
    send_idle_pct = 49;
    recv_idle_pct = 15;
    send_random(28);
    settle();

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(28);
    settle();

    $display("%0d directed and %0d random conversions across three pacing phases",
             dir_rows.size(), n_fields - dir_rows.size());
    $display("%0d characters checked, %0d mismatches", n_chars, n_errors);
    if (n_errors == 0) begin
      $display("[signed_decimal_field_formatter] OK");
    end else begin
      $display("[signed_decimal_field_formatter] ERROR");
    end
    $finish;
  end

endmodule
